// File: rtl/core/fpdns_pkg.sv
package fpdns_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned HDR_W  = 6;
  localparam int unsigned LEFT_W = 7;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned NAME_W = 48;

  localparam logic [POS_W-1:0]  POS_MAX          = 16'hffff;
  localparam logic [POS_W-1:0]  IDX_ETYPE_HI     = 16'd12;
  localparam logic [POS_W-1:0]  IDX_ETYPE_LO     = 16'd13;
  localparam logic [POS_W-1:0]  IDX_VER_IHL      = 16'd14;
  localparam logic [POS_W-1:0]  IDX_PROTOCOL     = 16'd23;
  localparam logic [POS_W-1:0]  IDX_MIN_LAST     = 16'd33;
  localparam logic [POS_W-1:0]  OFS_DPORT_HI     = 16'd16;
  localparam logic [POS_W-1:0]  OFS_DPORT_LO     = 16'd17;
  localparam logic [POS_W-1:0]  OFS_PORTS_LAST   = 16'd17;
  localparam logic [POS_W-1:0]  OFS_UDP_PAYLOAD  = 16'd22;
  localparam logic [POS_W-1:0]  OFS_DNS_NAME     = 16'd34;

  localparam logic [7:0]        ETYPE_HI         = 8'h08;
  localparam logic [7:0]        ETYPE_LO         = 8'h00;
  localparam logic [3:0]        IP_VERSION4      = 4'd4;
  localparam logic [HDR_W-1:0]  HDR_MIN          = 6'd20;
  localparam logic [7:0]        PROTO_TCP        = 8'd6;
  localparam logic [7:0]        PROTO_UDP        = 8'd17;
  localparam logic [PORT_W-1:0] DNS_PORT         = 16'd53;
  localparam logic [7:0]        LABEL_MAX        = 8'd63;
  localparam logic [7:0]        LABEL_WATCH      = 8'd6;

  localparam logic [PORT_W-1:0] BLOCKED_PORT_RST = 16'd42197;
  localparam logic [NAME_W-1:0] BLOCKED_NAME_RST = 48'h656167757365;

  typedef enum logic [0:0] {
    CFG_BLOCKED_PORT = 1'b0,
    CFG_BLOCKED_NAME = 1'b1
  } cfg_addr_t;

  typedef enum logic [1:0] {
    REASON_PASS = 2'd0,
    REASON_PORT = 2'd1,
    REASON_NAME = 2'd2
  } reason_t;

  typedef struct packed {
    logic    drop;
    reason_t reason;
  } verdict_t;

endpackage

// File: rtl/core/fpdns_parse.sv
module fpdns_parse (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [7:0]                     frame_byte,
  input  logic                           last_byte,
  input  logic [fpdns_pkg::PORT_W-1:0]   blocked_port,
  input  logic [fpdns_pkg::NAME_W-1:0]   blocked_name,
  output fpdns_pkg::verdict_t            verdict
);

  logic [fpdns_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                         eth_ok_r, eth_ok_nxt;
  logic                         ver_ok_r, ver_ok_nxt;
  logic [fpdns_pkg::HDR_W-1:0]  hdr_r, hdr_nxt;
  logic [7:0]                   proto_r, proto_nxt;
  logic [fpdns_pkg::PORT_W-1:0] dport_r, dport_nxt;
  logic [fpdns_pkg::POS_W-1:0]  nlp_r, nlp_nxt;
  logic [fpdns_pkg::LEFT_W-1:0] left_r, left_nxt;
  logic                         six_r, six_nxt;
  logic                         matching_r, matching_nxt;
  logic                         walk_done_r, walk_done_nxt;
  logic                         hit_r, hit_nxt;

  logic [fpdns_pkg::POS_W-1:0]  hdr_ext;
  logic [fpdns_pkg::POS_W:0]    nlp_sum;
  logic [2:0]                   want_sel;
  logic [7:0]                   want_byte;
  logic                         byte_ok;
  logic                         ip_valid;

  assign hdr_ext  = {{(fpdns_pkg::POS_W-fpdns_pkg::HDR_W){1'b0}}, hdr_nxt};
  assign nlp_sum  = {1'b0, pos_r} + {{(fpdns_pkg::POS_W-7){1'b0}}, 8'd1}
                    + {{(fpdns_pkg::POS_W-7){1'b0}}, frame_byte};
  assign want_sel = left_r[2:0] - 3'd1;
  assign want_byte = blocked_name[{want_sel, 3'b000} +: 8];
  assign byte_ok  = !six_r || (frame_byte == want_byte);

  always_comb begin
    pos_nxt       = (pos_r == fpdns_pkg::POS_MAX) ? pos_r : pos_r + 16'd1;
    eth_ok_nxt    = eth_ok_r;
    ver_ok_nxt    = ver_ok_r;
    hdr_nxt       = hdr_r;
    proto_nxt     = proto_r;
    dport_nxt     = dport_r;
    nlp_nxt       = nlp_r;
    left_nxt      = left_r;
    six_nxt       = six_r;
    matching_nxt  = matching_r;
    walk_done_nxt = walk_done_r;
    hit_nxt       = hit_r;

    if (pos_r == fpdns_pkg::POS_MAX) begin
      walk_done_nxt = 1'b1;
    end else begin
      if (pos_r == fpdns_pkg::IDX_ETYPE_HI) begin
        eth_ok_nxt = (frame_byte == fpdns_pkg::ETYPE_HI);
      end else if (pos_r == fpdns_pkg::IDX_ETYPE_LO) begin
        eth_ok_nxt = eth_ok_r && (frame_byte == fpdns_pkg::ETYPE_LO);
      end else if (pos_r == fpdns_pkg::IDX_VER_IHL) begin
        ver_ok_nxt = (frame_byte[7:4] == fpdns_pkg::IP_VERSION4);
        hdr_nxt    = {frame_byte[3:0], 2'b00};
        if ({frame_byte[3:0], 2'b00} < fpdns_pkg::HDR_MIN) begin
          walk_done_nxt = 1'b1;
        end else begin
          nlp_nxt = {{(fpdns_pkg::POS_W-fpdns_pkg::HDR_W){1'b0}}, frame_byte[3:0], 2'b00}
                    + fpdns_pkg::OFS_DNS_NAME;
        end
      end else if (pos_r == fpdns_pkg::IDX_PROTOCOL) begin
        proto_nxt = frame_byte;
      end

      if (pos_r > fpdns_pkg::IDX_VER_IHL && hdr_r >= fpdns_pkg::HDR_MIN) begin
        if (pos_r == hdr_ext + fpdns_pkg::OFS_DPORT_HI) begin
          dport_nxt = {frame_byte, dport_r[7:0]};
        end else if (pos_r == hdr_ext + fpdns_pkg::OFS_DPORT_LO) begin
          dport_nxt = {dport_r[15:8], frame_byte};
        end

        if (!walk_done_r && !hit_r) begin
          if (left_r == '0) begin
            if (pos_r == nlp_r) begin
              if (frame_byte == 8'd0 || frame_byte > fpdns_pkg::LABEL_MAX) begin
                walk_done_nxt = 1'b1;
              end else begin
                left_nxt     = frame_byte[fpdns_pkg::LEFT_W-1:0];
                six_nxt      = (frame_byte == fpdns_pkg::LABEL_WATCH);
                matching_nxt = 1'b1;
                nlp_nxt      = nlp_sum[fpdns_pkg::POS_W] ? fpdns_pkg::POS_MAX
                                                         : nlp_sum[fpdns_pkg::POS_W-1:0];
              end
            end
          end else begin
            matching_nxt = matching_r && byte_ok;
            left_nxt     = left_r - 7'd1;
            if (left_r == 7'd1 && six_r && matching_r && byte_ok) begin
              hit_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    ip_valid = (pos_r >= fpdns_pkg::IDX_MIN_LAST) && eth_ok_nxt && ver_ok_nxt
               && (hdr_nxt >= fpdns_pkg::HDR_MIN)
               && (pos_r >= hdr_ext + fpdns_pkg::OFS_PORTS_LAST);
    verdict.drop   = 1'b0;
    verdict.reason = fpdns_pkg::REASON_PASS;
    if (ip_valid && (proto_nxt == fpdns_pkg::PROTO_TCP || proto_nxt == fpdns_pkg::PROTO_UDP)
        && dport_nxt == blocked_port) begin
      verdict.drop   = 1'b1;
      verdict.reason = fpdns_pkg::REASON_PORT;
    end else if (ip_valid && proto_nxt == fpdns_pkg::PROTO_UDP
                 && dport_nxt == fpdns_pkg::DNS_PORT
                 && pos_r >= hdr_ext + fpdns_pkg::OFS_UDP_PAYLOAD && hit_nxt) begin
      verdict.drop   = 1'b1;
      verdict.reason = fpdns_pkg::REASON_NAME;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      pos_r       <= '0;
      eth_ok_r    <= 1'b0;
      ver_ok_r    <= 1'b0;
      hdr_r       <= '0;
      proto_r     <= '0;
      dport_r     <= '0;
      nlp_r       <= '0;
      left_r      <= '0;
      six_r       <= 1'b0;
      matching_r  <= 1'b0;
      walk_done_r <= 1'b0;
      hit_r       <= 1'b0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      eth_ok_r    <= eth_ok_nxt;
      ver_ok_r    <= ver_ok_nxt;
      hdr_r       <= hdr_nxt;
      proto_r     <= proto_nxt;
      dport_r     <= dport_nxt;
      nlp_r       <= nlp_nxt;
      left_r      <= left_nxt;
      six_r       <= six_nxt;
      matching_r  <= matching_nxt;
      walk_done_r <= walk_done_nxt;
      hit_r       <= hit_nxt;
    end
  end

endmodule

// File: rtl/core/frame_port_dns_label_filter.sv
// The verdict appears on out_tvalid from the result register; the last beat of a frame
// passes the input register first (one input register, one result register).
// Throughput: one frame byte per cycle; the only stall is a last beat held while the
// previous verdict still waits in the result register.
// Reset (rst_n low, synchronous) clears all frame state and restores the default
// blocked port and blocked name.
module frame_port_dns_label_filter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,  // [7:0] frame_byte
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata, // [0] drop, [2:1] reason, [7:3] zero
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_addr,
  input  logic [fpdns_pkg::NAME_W-1:0] cfg_wdata
);

  logic [fpdns_pkg::PORT_W-1:0] blocked_port_r;
  logic [fpdns_pkg::NAME_W-1:0] blocked_name_r;

  logic                s1_valid_r;
  logic [7:0]          s1_byte_r;
  logic                s1_last_r;
  logic                s1_go;
  logic                out_free;
  logic                out_valid_r;
  fpdns_pkg::verdict_t out_verdict_r;
  fpdns_pkg::verdict_t verdict;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocked_port_r <= fpdns_pkg::BLOCKED_PORT_RST;
      blocked_name_r <= fpdns_pkg::BLOCKED_NAME_RST;
    end else if (cfg_we) begin
      unique case (fpdns_pkg::cfg_addr_t'(cfg_addr))
        fpdns_pkg::CFG_BLOCKED_PORT: blocked_port_r <= cfg_wdata[fpdns_pkg::PORT_W-1:0];
        fpdns_pkg::CFG_BLOCKED_NAME: blocked_name_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  fpdns_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_go),
    .frame_byte   (s1_byte_r),
    .last_byte    (s1_last_r),
    .blocked_port (blocked_port_r),
    .blocked_name (blocked_name_r),
    .verdict      (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_verdict_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_verdict_r.reason, out_verdict_r.drop};

`ifndef ASSERT_OFF
  a_drop_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[2:1] != 2'd0)))
    else $error("drop flag disagrees with reason");

  a_reason_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:1] != 2'd3))
    else $error("undefined reason code");

  a_verdict_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && s1_last_r))
    else $error("verdict without a last beat");

  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("last beat taken while verdict pending");
`endif

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fpdns_pkg::*;

  localparam logic [15:0] ETYPE_IPV4 = {ETYPE_HI, ETYPE_LO};

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;   // [7:0] frame_byte
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;       // [0] drop, [2:1] reason, [7:3] zero
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_addr = '0;
  logic [NAME_W-1:0] cfg_wdata = '0;

  frame_port_dns_label_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Filter state mirrored on the testbench side.
  logic [PORT_W-1:0] port_block = BLOCKED_PORT_RST;
  logic [NAME_W-1:0] name_block = BLOCKED_NAME_RST;
  logic [POS_W-1:0]  pos_q = '0;
  bit                etype_ok;
  bit                ver_ok;
  logic [HDR_W-1:0]  hdr_len = '0;
  logic [7:0]        proto = '0;
  logic [PORT_W-1:0] dport = '0;
  logic [POS_W-1:0]  label_at = '0;
  logic [LEFT_W-1:0] label_rem = '0;
  bit                six_len;
  bit                six_same;
  bit                walk_off;
  bit                name_found;
  verdict_t          verdicts_due[$];

  frame_beat_t       pending_beats[$];
  logic [7:0]        frame_buf[$];
  int                bytes_made = 0;
  int                frames_made = 0;
  bit                sender_smooth = 1'b0;
  bit                took_beat = 1'b0;
  int                send_gap = 0;
  int                stall_left = 0;
  int                hold_left = 0;
  int                next_hold = 4;
  int                verdicts_seen = 0;
  int                fail_count = 0;

  task automatic parse_frame_byte(input logic [7:0] b, input logic last);
    int idx;
    int hs;
    int len;
    int sel;
    bit ok;
    verdict_t v;
    idx = pos_q;
    hs = hdr_len;
    if (idx >= POS_MAX) begin
      walk_off = 1'b1;
    end else begin
      if (idx == IDX_ETYPE_HI) begin
        etype_ok = (b == ETYPE_HI);
      end else if (idx == IDX_ETYPE_LO) begin
        etype_ok = etype_ok && (b == ETYPE_LO);
      end else if (idx == IDX_VER_IHL) begin
        ver_ok = (b[7:4] == IP_VERSION4);
        hdr_len = {b[3:0], 2'b00};
        hs = hdr_len;
        if (hs < HDR_MIN) walk_off = 1'b1;
        else label_at = 16'(hs + OFS_DNS_NAME);
      end else if (idx == IDX_PROTOCOL) begin
        proto = b;
      end
      if (idx > IDX_VER_IHL && hs >= HDR_MIN) begin
        if (idx == 14 + hs + 2) dport[15:8] = b;
        else if (idx == 14 + hs + 3) dport[7:0] = b;
        if (!walk_off && !name_found) begin
          if (label_rem == 0) begin
            if (idx == label_at) begin
              if (b == 0 || b > LABEL_MAX) begin
                walk_off = 1'b1;
              end else begin
                label_rem = b[6:0];
                six_len = (b == LABEL_WATCH);
                six_same = 1'b1;
                label_at = (idx + 1 + b > POS_MAX) ? POS_MAX : 16'(idx + 1 + b);
              end
            end
          end else begin
            sel = label_rem - 1;
            if (six_len && b != name_block[8*sel +: 8]) six_same = 1'b0;
            label_rem = label_rem - 1'b1;
            if (label_rem == 0 && six_len && six_same) name_found = 1'b1;
          end
        end
      end
    end
    if (pos_q != POS_MAX) pos_q = pos_q + 1'b1;
    if (last) begin
      len = idx + 1;
      ok = len >= 34 && etype_ok && ver_ok && hs >= HDR_MIN && 14 + hs + 4 <= len;
      v.drop = 1'b0;
      v.reason = REASON_PASS;
      if (ok && (proto == PROTO_TCP || proto == PROTO_UDP) && dport == port_block) begin
        v.drop = 1'b1;
        v.reason = REASON_PORT;
      end else if (ok && proto == PROTO_UDP && dport == DNS_PORT && len > 14 + hs + 8 &&
                   name_found) begin
        v.drop = 1'b1;
        v.reason = REASON_NAME;
      end
      verdicts_due.insert(verdicts_due.size(), v);
      pos_q = '0;
      etype_ok = 1'b0;
      ver_ok = 1'b0;
      hdr_len = '0;
      proto = '0;
      dport = '0;
      label_at = '0;
      label_rem = '0;
      six_len = 1'b0;
      six_same = 1'b0;
      walk_off = 1'b0;
      name_found = 1'b0;
    end
  endtask

  function automatic int pick_gap(input bit smooth);
    int r;
    r = $urandom_range(0, 99);
    if (smooth || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    took_beat <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        verdicts_seen <= verdicts_seen + 1;
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, actual drop=%0b reason=%0d",
                   $time, out_tdata[0], out_tdata[2:1]);
          fail_count++;
        end else begin
          want = verdicts_due[0];
          verdicts_due.delete(0);
          if (out_tdata[0] !== want.drop) begin
            $display("%0t: drop mismatch, expected %0b, actual %0b",
                     $time, want.drop, out_tdata[0]);
            fail_count++;
          end
          if (out_tdata[2:1] !== want.reason) begin
            $display("%0t: reason mismatch, expected %0d, actual %0d",
                     $time, want.reason, out_tdata[2:1]);
            fail_count++;
          end
          if (out_tdata[7:3] !== 5'd0) begin
            $display("%0t: padding mismatch, expected 0, actual %0h", $time, out_tdata[7:3]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) parse_frame_byte(in_tdata, in_tlast);
    end
  end

  always @(negedge clk) begin
    frame_beat_t nxt;
    if (rst_n && (!in_tvalid || took_beat)) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_beats.size() != 0) begin
        nxt = pending_beats[0];
        pending_beats.delete(0);
        in_tvalid <= 1'b1;
        in_tdata <= nxt.data;
        in_tlast <= nxt.last;
        send_gap <= pick_gap(sender_smooth);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random, and twice holds off long enough for the
  // filter to back up into its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (verdicts_seen >= next_hold && next_hold <= 12) begin
      out_tready <= 1'b0;
      hold_left <= 600;
      next_hold <= next_hold + 8;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap(1'b0);
    end
  end

  task automatic write_reg(input cfg_addr_t a, input logic [NAME_W-1:0] d);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = a;
    cfg_wdata = d;
    @(negedge clk);
    cfg_we = 1'b0;
    if (a == CFG_BLOCKED_PORT) port_block = d[PORT_W-1:0];
    else name_block = d;
  endtask

  task automatic put_byte(input logic [7:0] b);
    frame_buf.insert(frame_buf.size(), b);
  endtask

  task automatic build_header(input logic [3:0] ihl, input logic [7:0] prot,
                              input logic [15:0] dp, input logic [15:0] etype,
                              input logic [3:0] ver);
    frame_buf.delete();
    repeat (12) put_byte(8'($urandom));
    put_byte(etype[15:8]);
    put_byte(etype[7:0]);
    put_byte({ver, ihl});
    for (int i = 15; i < 14 + 4 * ihl || i < 24; i++)
      put_byte(i == IDX_PROTOCOL ? prot : 8'($urandom));
    repeat (2) put_byte(8'($urandom));
    put_byte(dp[15:8]);
    put_byte(dp[7:0]);
    repeat (16) put_byte(8'($urandom));
  endtask

  task automatic add_label(input int n, input bit use_name);
    put_byte(8'(n));
    if (n <= LABEL_MAX) begin
      for (int k = 0; k < n; k++)
        put_byte((use_name && n == 6) ? name_block[8*(5-k) +: 8] : 8'($urandom));
    end
  endtask

  task automatic spoil_label();
    int k;
    k = frame_buf.size() - 1 - $urandom_range(0, 5);
    frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
  endtask

  task automatic cut_frame(input int keep);
    while (frame_buf.size() > keep) void'(frame_buf.pop_back());
  endtask

  task automatic send_frame();
    frame_beat_t bt;
    foreach (frame_buf[i]) begin
      bt.data = frame_buf[i];
      bt.last = (i == frame_buf.size() - 1);
      pending_beats.insert(pending_beats.size(), bt);
    end
    bytes_made += frame_buf.size();
    frames_made++;
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_tvalid) @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int byte_goal, input int frame_goal);
    int b0;
    int f0;
    int r;
    int pick;
    logic [7:0] prot;
    logic [15:0] dp;
    b0 = bytes_made;
    f0 = frames_made;
    while (bytes_made - b0 < byte_goal || frames_made - f0 < frame_goal) begin
      pick = $urandom_range(0, 99);
      prot = pick < 60 ? PROTO_UDP : pick < 85 ? PROTO_TCP : 8'($urandom);
      pick = $urandom_range(0, 99);
      dp = pick < 50 ? DNS_PORT : pick < 70 ? port_block : 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        frame_buf.delete();
        repeat ($urandom_range(1, 40)) put_byte(8'($urandom));
      end else begin
        if (r < 75)
          build_header(($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5,
                       prot, dp, ETYPE_IPV4, IP_VERSION4);
        else
          build_header(4'($urandom), prot, dp,
                       $urandom_range(0, 1) ? ETYPE_IPV4 : 16'($urandom),
                       $urandom_range(0, 1) ? IP_VERSION4 : 4'($urandom));
        repeat ($urandom_range(0, 4)) begin
          pick = $urandom_range(0, 99);
          if (pick < 40) begin
            add_label(6, 1'b1);
          end else if (pick < 55) begin
            add_label(6, 1'b1);
            spoil_label();
          end else if (pick < 85) begin
            add_label($urandom_range(1, 20), 1'b0);
          end else if (pick < 92) begin
            add_label(0, 1'b0);
          end else begin
            add_label($urandom_range(64, 255), 1'b0);
          end
        end
        if ($urandom_range(0, 9) < 7) put_byte(8'h00);
        repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
        if ($urandom_range(0, 99) < 15) cut_frame($urandom_range(1, frame_buf.size()));
      end
      send_frame();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    frame_buf.delete();
    put_byte(8'hff);
    send_frame();
    frame_buf.delete();
    repeat (40) put_byte(8'h00);
    send_frame();
    frame_buf.delete();
    repeat (40) put_byte(8'hff);
    send_frame();

    // Blocked TCP port in the shortest frame that holds the ports, then one byte short.
    build_header(4'd5, PROTO_TCP, port_block, ETYPE_IPV4, IP_VERSION4);
    cut_frame(38);
    send_frame();
    build_header(4'd5, PROTO_TCP, port_block, ETYPE_IPV4, IP_VERSION4);
    cut_frame(37);
    send_frame();
    build_header(4'd5, PROTO_UDP, port_block, ETYPE_IPV4, IP_VERSION4);
    send_frame();
    build_header(4'd5, 8'd1, port_block, ETYPE_IPV4, IP_VERSION4);
    send_frame();

    build_header(4'd5, PROTO_UDP, DNS_PORT, ETYPE_IPV4, IP_VERSION4);
    add_label(6, 1'b1);
    put_byte(8'h00);
    send_frame();
    build_header(4'd15, PROTO_UDP, DNS_PORT, ETYPE_IPV4, IP_VERSION4);
    add_label(4, 1'b0);
    add_label(6, 1'b1);
    put_byte(8'h00);
    send_frame();
    build_header(4'd5, PROTO_TCP, DNS_PORT, ETYPE_IPV4, IP_VERSION4);
    add_label(6, 1'b1);
    send_frame();

    // A UDP datagram of exactly eight bytes, its header alone, leaves no room for a DNS name.
    build_header(4'd5, PROTO_UDP, DNS_PORT, ETYPE_IPV4, IP_VERSION4);
    cut_frame(42);
    send_frame();

    build_header(4'd4, PROTO_UDP, DNS_PORT, ETYPE_IPV4, IP_VERSION4);
    add_label(6, 1'b1);
    send_frame();
    build_header(4'd0, PROTO_TCP, port_block, ETYPE_IPV4, IP_VERSION4);
    add_label(6, 1'b1);
    send_frame();

    build_header(4'd5, PROTO_UDP, DNS_PORT, ETYPE_IPV4, IP_VERSION4);
    add_label(0, 1'b0);
    add_label(6, 1'b1);
    send_frame();
    build_header(4'd5, PROTO_UDP, DNS_PORT, ETYPE_IPV4, IP_VERSION4);
    add_label(64, 1'b0);
    add_label(6, 1'b1);
    send_frame();
    build_header(4'd5, PROTO_UDP, DNS_PORT, ETYPE_IPV4, IP_VERSION4);
    add_label(63, 1'b0);
    add_label(6, 1'b1);
    send_frame();

    build_header(4'd5, PROTO_UDP, DNS_PORT, ETYPE_IPV4, IP_VERSION4);
    add_label(6, 1'b1);
    void'(frame_buf.pop_back());
    send_frame();

    build_header(4'd5, PROTO_UDP, DNS_PORT, ETYPE_IPV4, IP_VERSION4);
    add_label(6, 1'b1);
    add_label(6, 1'b1);
    spoil_label();
    add_label(70, 1'b0);
    send_frame();

    build_header(4'd5, PROTO_UDP, DNS_PORT, ETYPE_IPV4, IP_VERSION4);
    put_byte(8'd7);
    for (int k = 0; k < 6; k++) put_byte(name_block[8*(5-k) +: 8]);
    put_byte(8'($urandom));
    put_byte(8'h00);
    send_frame();

    build_header(4'd5, PROTO_TCP, port_block, 16'h86dd, IP_VERSION4);
    send_frame();
    build_header(4'd5, PROTO_TCP, port_block, ETYPE_IPV4, 4'd6);
    send_frame();
    drain();

    write_reg(CFG_BLOCKED_PORT, '0);
    write_reg(CFG_BLOCKED_NAME, '0);
    random_phase(40, 1);
    drain();

    sender_smooth = 1'b1;
    write_reg(CFG_BLOCKED_PORT, NAME_W'(16'hffff));
    write_reg(CFG_BLOCKED_NAME, '1);
    random_phase(40, 1);
    drain();
    sender_smooth = 1'b0;

    write_reg(CFG_BLOCKED_PORT, NAME_W'(DNS_PORT));
    write_reg(CFG_BLOCKED_NAME, NAME_W'({$urandom, $urandom}));
    random_phase(40, 1);
    drain();

    write_reg(CFG_BLOCKED_PORT, NAME_W'(16'($urandom)));
    write_reg(CFG_BLOCKED_NAME, NAME_W'({$urandom, $urandom}));
    random_phase(40, 1);
    drain();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
